/* hw/rtl/alwc_pkg.sv */
// Shared types and codes for the array list with cursor.
`default_nettype none

package alwc_pkg;

    // Default sizing of the list.
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Operation codes carried in the mode field.
    localparam logic [3:0] MODE_INSERT  = 4'd0;
    localparam logic [3:0] MODE_APPEND  = 4'd1;
    localparam logic [3:0] MODE_REMOVE  = 4'd2;
    localparam logic [3:0] MODE_DEQUEUE = 4'd3;
    localparam logic [3:0] MODE_START   = 4'd4;
    localparam logic [3:0] MODE_END     = 4'd5;
    localparam logic [3:0] MODE_PREV    = 4'd6;
    localparam logic [3:0] MODE_NEXT    = 4'd7;
    localparam logic [3:0] MODE_SETPOS  = 4'd8;
    localparam logic [3:0] MODE_CLEAR   = 4'd9;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // One command item.
    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] item_value;
        logic [6:0]         position;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic signed [31:0] current_value;
        logic [6:0]         entry_count;
        logic [5:0]         cursor_index;
    } t_out_item;

endpackage

`default_nettype wire

/* hw/rtl/array_list_with_cursor_top.sv */
// Top level of the array list with cursor: sequencer around a single-port-pair entry memory.
// Cursor moves, clear and failed operations pass through S_LOOK and S_FETCH to the result;
//   the next item is accepted only once the result is built and the sequencer is in S_IDLE.
// Insert shifts entries up through S_SHIFT_UP, S_UP_LAST and S_PUT, remove or dequeue reads
//   them through S_SHIFT_DN and S_DN_LAST, one entry per cycle through the memory.
// Synchronous active-low reset empties the list and clears the cursor; stored words stay.
`default_nettype none

module array_list_with_cursor_top #(
    parameter int CAPACITY   = alwc_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = alwc_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire alwc_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output alwc_pkg::t_out_item      o_out_item
);
    import alwc_pkg::*;

    localparam int NW = $clog2(CAPACITY + 1);
    localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (NW > 7) ? NW : 7;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SHIFT_UP = 8'b0000_0010,
        S_UP_LAST  = 8'b0000_0100,
        S_PUT      = 8'b0000_1000,
        S_SHIFT_DN = 8'b0001_0000,
        S_DN_LAST  = 8'b0010_0000,
        S_LOOK     = 8'b0100_0000,
        S_FETCH    = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [NW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_cursor, n_cursor;
    logic [CW-1:0]         r_addr, n_addr;
    logic [CW-1:0]         r_waddr, n_waddr;
    logic                  r_dv, n_dv;
    logic                  r_dfirst, n_dfirst;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [1:0]            r_status, n_status;
    logic [31:0]           r_removed, n_removed;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    // Entry memory and its registered read data.
    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic                  mem_we;
    logic [CW-1:0]         mem_waddr;
    logic [CW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    logic [DATA_WIDTH-1:0] in_word;
    logic [PW-1:0]         pos_w;
    logic [PW-1:0]         count_w;
    logic                  is_full;
    logic                  cursor_in_list;
    logic                  out_free;

    assign in_word        = DATA_WIDTH'($signed(i_in_item.item_value));
    assign pos_w          = PW'(i_in_item.position);
    assign count_w        = PW'(r_count);
    assign is_full        = (r_count == NW'(CAPACITY));
    assign cursor_in_list = (NW'(r_cursor) < r_count);
    assign out_free       = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Sequencer. Shifts walk away from the write address, so a read never meets a
    // pending write to the same entry; the cursor read is made in S_LOOK, once the last write is done.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_addr      = r_addr;
        n_waddr     = r_waddr;
        n_dv        = r_dv;
        n_dfirst    = r_dfirst;
        n_val       = r_val;
        n_status    = r_status;
        n_removed   = r_removed;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_waddr;
        mem_wdata   = r_rdata;
        mem_raddr   = r_cursor;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status  = ST_OK;
                    n_removed = '0;
                    n_val     = in_word;
                    n_dv      = 1'b0;
                    n_state   = S_LOOK;
                    case (i_in_item.mode)
                        MODE_INSERT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                                if (cursor_in_list) begin
                                    n_addr  = CW'(r_count - 1'b1);
                                    n_state = S_SHIFT_UP;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_waddr = r_cursor;
                                    mem_wdata = in_word;
                                end
                            end
                        end
                        MODE_APPEND: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count   = r_count + 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = CW'(r_count);
                                mem_wdata = in_word;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (!cursor_in_list) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_count = r_count - 1'b1;
                                n_addr  = r_cursor;
                                n_state = S_SHIFT_DN;
                            end
                        end
                        MODE_DEQUEUE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cursor = '0;
                                n_count  = r_count - 1'b1;
                                n_addr   = '0;
                                n_state  = S_SHIFT_DN;
                            end
                        end
                        MODE_START: begin
                            n_cursor = '0;
                        end
                        MODE_END: begin
                            n_cursor = (r_count == '0) ? '0 : CW'(r_count - 1'b1);
                        end
                        MODE_PREV: begin
                            if (r_cursor == '0) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_cursor = r_cursor - 1'b1;
                            end
                        end
                        MODE_NEXT: begin
                            if ((NW'(r_cursor) + 1'b1) >= r_count) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_cursor = r_cursor + 1'b1;
                            end
                        end
                        MODE_SETPOS: begin
                            if ((pos_w != '0) && (pos_w <= count_w)) begin
                                n_cursor = CW'(pos_w - 1'b1);
                            end else begin
                                n_status = ST_BADPOS;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Move entries up by one, from the back down to the cursor.
            S_SHIFT_UP: begin
                mem_raddr = r_addr;
                mem_we    = r_dv;
                n_waddr   = r_addr + 1'b1;
                n_dv      = 1'b1;
                if (r_addr == r_cursor) begin
                    n_state = S_UP_LAST;
                end else begin
                    n_addr = r_addr - 1'b1;
                end
            end

            S_UP_LAST: begin
                mem_we  = 1'b1;
                n_state = S_PUT;
            end

            // Place the new value at the cursor.
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cursor;
                mem_wdata = r_val;
                n_state   = S_LOOK;
            end

            // Move entries down by one; the first word read is the one taken out.
            S_SHIFT_DN: begin
                mem_raddr = r_addr;
                if (r_dv) begin
                    if (r_dfirst) begin
                        n_removed = 32'($signed(r_rdata));
                    end else begin
                        mem_we = 1'b1;
                    end
                end
                n_dfirst = !r_dv;
                n_dv     = 1'b1;
                n_waddr  = r_addr - 1'b1;
                if (NW'(r_addr) == r_count) begin
                    n_state = S_DN_LAST;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            S_DN_LAST: begin
                if (r_dfirst) begin
                    n_removed = 32'($signed(r_rdata));
                end else begin
                    mem_we = 1'b1;
                end
                n_state = S_LOOK;
            end

            // Read the entry under the cursor.
            S_LOOK: begin
                n_state = S_FETCH;
            end

            // Build the result once the output register is free.
            S_FETCH: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_status;
                    n_out.removed_value = r_removed;
                    n_out.current_value = cursor_in_list ? 32'($signed(r_rdata)) : '0;
                    n_out.entry_count   = 7'(r_count);
                    n_out.cursor_index  = 6'(r_cursor);
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_dfirst    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
            r_dv        <= n_dv;
            r_dfirst    <= n_dfirst;
        end
    end

    // Payload and address registers.
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_waddr   <= n_waddr;
        r_val     <= n_val;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_out     <= n_out;
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/alwc_checker.sv */
// Port-level checks for the array list with cursor, bound to the top level.
`default_nettype none

module alwc_checker #(
    parameter int CAPACITY = alwc_pkg::DEF_CAPACITY
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire alwc_pkg::t_in_item  i_in_item,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire alwc_pkg::t_out_item o_out_item
);
    import alwc_pkg::*;

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or vanished");

    // One item at a time: an input transfer closes the input until its result is built.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 64) || (32'(o_out_item.entry_count) <= CAPACITY))
        else $error("entry count above capacity");

    // A cursor past the last entry shows no current value.
    a_cursor_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 64)
            || (7'(o_out_item.cursor_index) < o_out_item.entry_count)
            || (o_out_item.current_value == '0))
        else $error("current value shown beyond the list");

    // An empty report means nothing was removed and the list holds nothing.
    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_EMPTY)
            |-> (o_out_item.entry_count == '0) && (o_out_item.removed_value == '0))
        else $error("empty status with entries or a removed value");

endmodule

bind array_list_with_cursor_top alwc_checker #(
    .CAPACITY(CAPACITY)
) u_alwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the array list with cursor: directed and random command streams.
`default_nettype none

module testbench;

    import alwc_pkg::*;

    localparam int LIST_CAPACITY = DEF_CAPACITY;
    localparam int STALL_PERCENT = 10;
    localparam int RANDOM_OPS    = 800;
    localparam int WATCHDOG_LIMIT = 4000;

    // Mode codes outside the defined operations, which the block treats as no operation.
    localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
    localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Predicted contents of the list, kept in step with accepted commands.
    logic signed [31:0] list_words [LIST_CAPACITY];
    int list_count = 0;
    int list_cursor = 0;

    t_out_item list_results_due [$];
    int  failure_count = 0;
    int  idle_cycles = 0;
    int  fill_target = 0;
    bit  steady_traffic = 1'b0;

    array_list_with_cursor_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void report_failure(input string msg);
        failure_count++;
        if (failure_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    // Takes the entry under the cursor and closes the gap behind it.
    function automatic logic signed [31:0] take_under_cursor();
        logic signed [31:0] taken;
        taken = list_words[list_cursor];
        for (int i = list_cursor; i + 1 < list_count; i++) begin
            list_words[i] = list_words[i + 1];
        end
        list_count--;
        return taken;
    endfunction

    // Applies one command to the predicted list and returns the result it should produce.
    function automatic t_out_item apply_list_op(input t_in_item op);
        t_out_item res;
        res = '0;
        res.status = ST_OK;
        case (op.mode)
            MODE_INSERT: begin
                if (list_count >= LIST_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_count; i > list_cursor; i--) begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[list_cursor] = op.item_value;
                    list_count++;
                end
            end
            MODE_APPEND: begin
                if (list_count >= LIST_CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_count] = op.item_value;
                    list_count++;
                end
            end
            MODE_REMOVE: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (list_cursor >= list_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.removed_value = take_under_cursor();
                end
            end
            MODE_DEQUEUE: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    list_cursor = 0;
                    res.removed_value = take_under_cursor();
                end
            end
            MODE_START: begin
                list_cursor = 0;
            end
            MODE_END: begin
                list_cursor = (list_count == 0) ? 0 : list_count - 1;
            end
            MODE_PREV: begin
                if (list_cursor == 0) begin
                    res.status = ST_BADPOS;
                end else begin
                    list_cursor--;
                end
            end
            MODE_NEXT: begin
                if (list_cursor + 1 >= list_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    list_cursor++;
                end
            end
            MODE_SETPOS: begin
                if (op.position >= 1 && op.position <= list_count) begin
                    list_cursor = op.position - 1;
                end else begin
                    res.status = ST_BADPOS;
                end
            end
            MODE_CLEAR: begin
                list_count = 0;
                list_cursor = 0;
            end
            default: begin
            end
        endcase
        res.current_value = (list_cursor < list_count) ? list_words[list_cursor] : '0;
        res.entry_count   = list_count[6:0];
        res.cursor_index  = list_cursor[5:0];
        return res;
    endfunction

    function automatic t_in_item make_op(input logic [3:0] mode, input logic [31:0] value,
                                         input logic [6:0] position);
        t_in_item op;
        op.mode       = mode;
        op.item_value = value;
        op.position   = position;
        return op;
    endfunction

    // Chooses a random command, steering the list towards a fill level that drifts over time.
    function automatic t_in_item pick_list_op();
        t_in_item op;
        int roll;
        bit grow;
        roll = $urandom_range(0, 99);
        grow = (list_count < fill_target);
        op.item_value = $urandom;
        if (list_count > 0 && $urandom_range(0, 3) != 0) begin
            op.position = 7'($urandom_range(1, list_count));
        end else begin
            op.position = 7'($urandom_range(0, 127));
        end
        if (roll < 2) begin
            op.mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end else if (roll < 3) begin
            op.mode = MODE_CLEAR;
        end else if (roll < (grow ? 60 : 18)) begin
            op.mode = $urandom_range(0, 1) ? MODE_INSERT : MODE_APPEND;
        end else if (roll < 76) begin
            op.mode = $urandom_range(0, 1) ? MODE_REMOVE : MODE_DEQUEUE;
        end else begin
            case ($urandom_range(0, 4))
                0: op.mode = MODE_START;
                1: op.mode = MODE_END;
                2: op.mode = MODE_PREV;
                3: op.mode = MODE_NEXT;
                default: op.mode = MODE_SETPOS;
            endcase
        end
        return op;
    endfunction

    // Offers one command, with random gaps beforehand, and records its result once transferred.
    task automatic send_item(input t_in_item op);
        while (!steady_traffic && $urandom_range(0, 99) < STALL_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= op;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        list_results_due.push_back(apply_list_op(op));
    endtask

    // Operations that must fail or do nothing on an empty list.
    task automatic test_empty_list();
        send_item(make_op(MODE_REMOVE, 32'h0000_0001, 7'd0));
        send_item(make_op(MODE_DEQUEUE, 32'h0000_0002, 7'd0));
        send_item(make_op(MODE_PREV, 32'h0, 7'd0));
        send_item(make_op(MODE_NEXT, 32'h0, 7'd0));
        send_item(make_op(MODE_END, 32'h0, 7'd0));
        send_item(make_op(MODE_SETPOS, 32'h0, 7'd1));
        send_item(make_op(MODE_UNUSED_HI, 32'hFFFF_FFFF, 7'h7F));
        send_item(make_op(MODE_CLEAR, 32'h0, 7'd0));
    endtask

    // Extreme words, cursor moves at both ends and removal past the last entry.
    task automatic test_extreme_values();
        send_item(make_op(MODE_APPEND, 32'h7FFF_FFFF, 7'd0));
        send_item(make_op(MODE_APPEND, 32'h8000_0000, 7'd0));
        send_item(make_op(MODE_INSERT, 32'hFFFF_FFFF, 7'd0));
        send_item(make_op(MODE_APPEND, 32'h0000_0000, 7'd0));
        send_item(make_op(MODE_SETPOS, 32'h0, 7'd0));
        send_item(make_op(MODE_SETPOS, 32'h0, 7'd127));
        send_item(make_op(MODE_SETPOS, 32'h0, 7'd4));
        send_item(make_op(MODE_NEXT, 32'h0, 7'd0));
        send_item(make_op(MODE_START, 32'h0, 7'd0));
        send_item(make_op(MODE_PREV, 32'h0, 7'd0));
        send_item(make_op(MODE_SETPOS, 32'h0, 7'd2));
        send_item(make_op(MODE_REMOVE, 32'h0, 7'd0));
        send_item(make_op(MODE_END, 32'h0, 7'd0));
        send_item(make_op(MODE_REMOVE, 32'h0, 7'd0));
        send_item(make_op(MODE_REMOVE, 32'h0, 7'd0));
        send_item(make_op(MODE_DEQUEUE, 32'h0, 7'd0));
        send_item(make_op(MODE_DEQUEUE, 32'h0, 7'd0));
    endtask

    // Fills the list to capacity, then pushes against the full and last-entry cases.
    task automatic test_full_list();
        send_item(make_op(MODE_CLEAR, 32'h0, 7'd0));
        for (int i = 0; i < LIST_CAPACITY; i++) begin
            send_item(make_op($urandom_range(0, 1) ? MODE_INSERT : MODE_APPEND, $urandom,
                              7'($urandom_range(0, 127))));
        end
        send_item(make_op(MODE_INSERT, $urandom, 7'd0));
        send_item(make_op(MODE_APPEND, $urandom, 7'd0));
        send_item(make_op(MODE_END, 32'h0, 7'd0));
        send_item(make_op(MODE_NEXT, 32'h0, 7'd0));
        send_item(make_op(MODE_SETPOS, 32'h0, 7'd64));
        send_item(make_op(MODE_REMOVE, 32'h0, 7'd0));
        send_item(make_op(MODE_START, 32'h0, 7'd0));
        send_item(make_op(MODE_INSERT, $urandom, 7'd0));
        send_item(make_op(MODE_REMOVE, 32'h0, 7'd0));
        send_item(make_op(MODE_DEQUEUE, 32'h0, 7'd0));
    endtask

    // Random command stream with a drifting fill level; one stretch runs without any gaps.
    task automatic test_random_ops();
        t_in_item op;
        int done;
        done = 0;
        while (done < RANDOM_OPS) begin
            if (done % 100 == 0) begin
                fill_target = $urandom_range(0, LIST_CAPACITY);
            end
            steady_traffic = (done >= 300 && done < 450);
            op = pick_list_op();
            send_item(op);
            if (op.mode <= MODE_CLEAR) begin
                done++;
            end
        end
        steady_traffic = 1'b0;
    endtask

    // Result side: random back-pressure, except during the steady stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !steady_traffic && ($urandom_range(0, 99) < STALL_PERCENT);
    end

    // Each result transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (list_results_due.size() == 0) begin
                report_failure($sformatf("result with nothing expected: %p", o_out_item));
            end else begin
                want = list_results_due.pop_front();
                if (o_out_item.status !== want.status
                        || o_out_item.removed_value !== want.removed_value
                        || o_out_item.current_value !== want.current_value
                        || o_out_item.entry_count !== want.entry_count
                        || o_out_item.cursor_index !== want.cursor_index) begin
                    report_failure($sformatf("result mismatch: expected %p, got %p",
                                             want, o_out_item));
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_extreme_values();
        test_full_list();
        test_random_ops();
        i_in_valid <= 1'b0;
        while (list_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LIST_CAPACITY + 16) @(posedge i_clk);
        if (failure_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/alwc_pkg.sv
hw/rtl/array_list_with_cursor_top.sv
hw/rtl/alwc_checker.sv
tb/sv/testbench.sv
